// File: sv/trv_pkg.sv
package trv_pkg;

  localparam int LenA          = 93;
  localparam int LenB          = 84;
  localparam int LenC          = 111;
  localparam int KeyW          = 80;
  localparam int CfgLowW       = 64;
  localparam int CfgHighW      = KeyW - CfgLowW;
  localparam int CfgIdxW       = 2;
  localparam int ByteW         = 8;
  localparam int WarmupSteps   = 1152;
  localparam int WarmupCycles  = WarmupSteps / ByteW;
  localparam int WarmCntW      = $clog2(WarmupCycles + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyLow  = 2'd0,
    RegKeyHigh = 2'd1,
    RegIvLow   = 2'd2,
    RegIvHigh  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OpInit = 1'b0,
    OpData = 1'b1
  } op_e;

  typedef struct packed {
    logic [LenA-1:0] a;
    logic [LenB-1:0] b;
    logic [LenC-1:0] c;
  } trv_state_t;

  typedef struct packed {
    trv_state_t       st;
    logic [ByteW-1:0] ks;
  } trv_step_t;

  typedef struct packed {
    logic load;
    logic advance;
  } trv_ctrl_t;

  // Eight bit steps; earliest keystream bit lands in bit 0.
  function automatic trv_step_t trv_step8(trv_state_t s);
    trv_state_t cur;
    trv_step_t  r;
    logic       t1, t2, t3;
    cur = s;
    r.ks = '0;
    for (int k = 0; k < ByteW; k++) begin
      t1 = cur.a[65] ^ cur.a[92];
      t2 = cur.b[68] ^ cur.b[83];
      t3 = cur.c[65] ^ cur.c[110];
      r.ks[k] = t1 ^ t2 ^ t3;
      t1 = t1 ^ (cur.a[90] & cur.a[91]) ^ cur.b[77];
      t2 = t2 ^ (cur.b[81] & cur.b[82]) ^ cur.c[86];
      t3 = t3 ^ (cur.c[108] & cur.c[109]) ^ cur.a[68];
      cur.a = {cur.a[LenA-2:0], t3};
      cur.b = {cur.b[LenB-2:0], t1};
      cur.c = {cur.c[LenC-2:0], t2};
    end
    r.st = cur;
    return r;
  endfunction

  function automatic trv_state_t trv_load(logic [KeyW-1:0] key, logic [KeyW-1:0] iv);
    trv_state_t s;
    s.a = {{(LenA-KeyW){1'b0}}, key};
    s.b = {{(LenB-KeyW){1'b0}}, iv};
    s.c = {3'b111, {(LenC-3){1'b0}}};
    return s;
  endfunction

endpackage

// File: sv/trv_state.sv
module trv_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  trv_pkg::trv_ctrl_t         ctrl_i,
  input  logic [trv_pkg::KeyW-1:0]   key_i,
  input  logic [trv_pkg::KeyW-1:0]   iv_i,
  output logic                       busy_o,
  output logic [trv_pkg::ByteW-1:0]  ks_o
);
  import trv_pkg::*;

  trv_state_t            state_q, state_d;
  logic [WarmCntW-1:0]   cnt_q, cnt_d;
  trv_step_t             step;

  assign step   = trv_step8(state_q);
  assign ks_o   = step.ks;
  assign busy_o = (cnt_q != '0);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    priority if (ctrl_i.load) begin
      state_d = trv_load(key_i, iv_i);
      cnt_d   = WarmCntW'(WarmupCycles);
    end else if (busy_o) begin
      state_d = step.st;
      cnt_d   = cnt_q - 1'b1;
    end else if (ctrl_i.advance) begin
      state_d = step.st;
    end else begin
      state_d = state_q;
      cnt_d   = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: sv/trivium_keystream_byte_top.sv
// Trivium keystream generator, one byte per beat. Write the 80-bit key and IV through the
// config port (index 0..3: key low 64, key high 16, IV low 64, IV high 16), then send an
// init beat (tuser = 0): it loads the state and runs the 1152 warm-up steps at eight steps
// per clock, so s_axis_tready stays low during the warm-up and no result beat is produced.
// Each data beat (tuser = 1) advances eight steps and returns {data ^ keystream, keystream}
// in the next cycle; data beats are accepted every cycle while the output register drains.
// Config values take effect at the next init beat. Before any init the keystream is zero.
module trivium_keystream_byte_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]                    s_axis_tuser_i,   // [0] operation
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,   // [7:0] keystream_byte, [15:8] result_byte
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trv_pkg::CfgLowW-1:0]   cfg_data_i
);
  import trv_pkg::*;

  logic [CfgLowW-1:0]   key_low_q, iv_low_q;
  logic [CfgHighW-1:0]  key_high_q, iv_high_q;
  trv_ctrl_t            ctrl;
  logic                 busy;
  logic [ByteW-1:0]     ks;
  logic                 accept;
  op_e                  op;
  logic                 out_valid_q;
  logic [2*ByteW-1:0]   out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      iv_low_q   <= '0;
      iv_high_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegKeyLow:  key_low_q  <= cfg_data_i;
        RegKeyHigh: key_high_q <= cfg_data_i[CfgHighW-1:0];
        RegIvLow:   iv_low_q   <= cfg_data_i;
        RegIvHigh:  iv_high_q  <= cfg_data_i[CfgHighW-1:0];
      endcase
    end
  end

  assign op              = op_e'(s_axis_tuser_i[0]);
  assign s_axis_tready_o = !busy && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign ctrl.load       = accept && (op == OpInit);
  assign ctrl.advance    = accept && (op == OpData);

  trv_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .key_i  ({key_high_q, key_low_q}),
    .iv_i   ({iv_high_q, iv_low_q}),
    .busy_o (busy),
    .ks_o   (ks)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.advance) begin
      out_data_q <= {s_axis_tdata_i ^ ks, ks};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: sv/trv_checker.sv
module trv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);
  import trv_pkg::*;

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // init holds off input during warm-up
  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[0] == OpInit) |=> !s_axis_tready_o)
    else $error("input ready right after init beat");

  a_init_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[0] == OpInit) && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("init beat produced a result");

  a_data_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[0] == OpData) |=>
      m_axis_tvalid_o && ((m_axis_tdata_o[15:8] ^ m_axis_tdata_o[7:0]) == $past(s_axis_tdata_i)))
    else $error("data beat result missing or result byte mismatch");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output beat changed");

endmodule

bind trivium_keystream_byte_top trv_checker u_trv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
